// ===== rtl/ptbe_pkg.sv =====
// ptbe_pkg: shared types and constants for the pulse threshold bpm estimator
// used by ptbe_regs, ptbe_div and pulse_threshold_bpm_estimator; no dependencies
package ptbe_pkg;

  // field widths fixed by the interface
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned THR_W    = 12;
  localparam int unsigned IVL_W    = 16;
  localparam int unsigned BLANK_W  = 10;
  localparam int unsigned RATE_W   = 8;

  // configuration port
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // divider: numerator and divisor both fit 16 bits
  localparam int unsigned DIV_W = 16;
  localparam logic [DIV_W-1:0] BPM_NUMERATOR = 16'd60000;

  // reset values
  localparam logic [THR_W-1:0]   THR_RESET   = 12'd2000;
  localparam logic [IVL_W-1:0]   MIN_RESET   = 16'd300;
  localparam logic [IVL_W-1:0]   MAX_RESET   = 16'd2000;
  localparam logic [BLANK_W-1:0] BLANK_RESET = 10'd200;
  localparam logic [RATE_W-1:0]  RATE_RESET  = 8'd72;
  localparam logic [RATE_W-1:0]  RATE_MAX    = 8'd255;

  // register index, taken from paddr word bits
  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_MIN_IVL   = 2'd1,
    REG_MAX_IVL   = 2'd2,
    REG_BLANK     = 2'd3
  } reg_idx_t;

  // configuration values seen by the datapath
  typedef struct packed {
    logic [THR_W-1:0]   beat_threshold;
    logic [IVL_W-1:0]   min_interval;
    logic [IVL_W-1:0]   max_interval;
    logic [BLANK_W-1:0] blank_ticks;
  } cfg_t;

endpackage

// ===== rtl/ptbe_regs.sv =====
// ptbe_regs: apb-style configuration registers of the estimator
// depends on ptbe_pkg for register indexes, widths and reset values
module ptbe_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptbe_pkg::ADDR_W-1:0]   paddr,
  input  logic [ptbe_pkg::DATA_W-1:0]   pwdata,
  output logic [ptbe_pkg::DATA_W-1:0]   prdata,
  output ptbe_pkg::cfg_t                cfg
);
  import ptbe_pkg::*;

  reg_idx_t idx;

  assign idx = reg_idx_t'(paddr[3:2]);

  // register write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.beat_threshold <= THR_RESET;
      cfg.min_interval   <= MIN_RESET;
      cfg.max_interval   <= MAX_RESET;
      cfg.blank_ticks    <= BLANK_RESET;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_THRESHOLD: cfg.beat_threshold <= pwdata[THR_W-1:0];
        REG_MIN_IVL:   cfg.min_interval   <= pwdata[IVL_W-1:0];
        REG_MAX_IVL:   cfg.max_interval   <= pwdata[IVL_W-1:0];
        REG_BLANK:     cfg.blank_ticks    <= pwdata[BLANK_W-1:0];
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    case (idx)
      REG_THRESHOLD: prdata = DATA_W'(cfg.beat_threshold);
      REG_MIN_IVL:   prdata = DATA_W'(cfg.min_interval);
      REG_MAX_IVL:   prdata = DATA_W'(cfg.max_interval);
      REG_BLANK:     prdata = DATA_W'(cfg.blank_ticks);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/ptbe_div.sv =====
// ptbe_div: restoring divider, one quotient bit per cycle, divides 60000 by the interval
// depends on ptbe_pkg for the divider width and numerator
module ptbe_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ptbe_pkg::DIV_W-1:0]  divisor,
  output logic                        done,
  output logic [ptbe_pkg::DIV_W-1:0]  quotient
);
  import ptbe_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

  logic             busy;
  logic [CNT_W-1:0] step;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   trial;
  logic             fits;

  // shift in the next dividend bit and try the subtraction
  assign trial = {rem, quotient[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  // quotient register holds the dividend bits still to come and the quotient bits so far
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step     <= '0;
      rem      <= '0;
      dvs      <= '0;
      quotient <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= BPM_NUMERATOR;
      end else if (busy) begin
        rem      <= fits ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
        quotient <= {quotient[DIV_W-2:0], fits};
        step     <= step + CNT_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/pulse_threshold_bpm_estimator.sv =====
// pulse_threshold_bpm_estimator: top level, beat detection and rate update sequencer
// depends on ptbe_pkg, ptbe_regs and ptbe_div
//
// Usage
//   Input channel: sample with in_valid / in_stall, one item per sensor tick.
//   Output channel: rate_bpm, beat_seen, rate_updated with out_valid / out_stall,
//   exactly one result item per input item, in order.
//   Configuration: apb-style port, registers at byte addresses 0 (beat_threshold),
//   4 (min_interval), 8 (max_interval), 12 (blank_ticks); pready is always high.
//   Write registers only while no item is in flight.
// Timing
//   An item that does not update the rate passes from the result registers through
//   ST_PUSH into the output register; the next item is taken once it is loaded.
//   An item that updates the rate runs the divider, one quotient bit per cycle
//   for all 16 quotient bits; its rate is then stored in held_rate in ST_DIV and
//   goes through ST_PUSH to the output register, after which the next item is taken.
//   in_stall is high while an item is being worked on.
// Reset and stall
//   Synchronous reset restores register defaults, clears the tick counter, the
//   prior-beat flag and blanking, and sets the held rate to 72 bpm.
//   A stalled result holds in the output register; a finished item waits for it.
module pulse_threshold_bpm_estimator #(
  parameter int unsigned ELAPSED_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // input item channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ptbe_pkg::SAMPLE_W-1:0]   sample,
  // result item channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ptbe_pkg::RATE_W-1:0]     rate_bpm,
  output logic                            beat_seen,
  output logic                            rate_updated,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ptbe_pkg::ADDR_W-1:0]     paddr,
  input  logic [ptbe_pkg::DATA_W-1:0]     pwdata,
  output logic [ptbe_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import ptbe_pkg::*;

  localparam int unsigned CMP_W = (ELAPSED_BITS > IVL_W) ? ELAPSED_BITS : IVL_W;
  localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } state_t;

  state_t                  state;
  cfg_t                    cfg;
  logic [ELAPSED_BITS-1:0] elapsed;
  logic [ELAPSED_BITS-1:0] elapsed_inc;
  logic                    have_prior;
  logic [BLANK_W-1:0]      blank_left;
  logic [RATE_W-1:0]       held_rate;
  logic                    res_beat;
  logic                    res_upd;
  logic                    accept;
  logic                    saturated;
  logic                    beat_now;
  logic                    qualify;
  logic                    out_free;
  logic                    div_done;
  logic [DIV_W-1:0]        div_q;

  assign pready   = 1'b1;
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  ptbe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // tick counter advance with saturation
  assign elapsed_inc = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + ELAPSED_BITS'(1);
  assign saturated   = (elapsed_inc == ELAPSED_MAX);

  // beat detection and interval check
  assign beat_now = (blank_left == '0) && (sample > cfg.beat_threshold);
  assign qualify  = beat_now && have_prior && !saturated &&
                    (CMP_W'(elapsed_inc) > CMP_W'(cfg.min_interval)) &&
                    (CMP_W'(elapsed_inc) < CMP_W'(cfg.max_interval));

  ptbe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && qualify),
    .divisor  (DIV_W'(elapsed_inc)),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer, beat state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      elapsed      <= '0;
      have_prior   <= 1'b0;
      blank_left   <= '0;
      held_rate    <= RATE_RESET;
      res_beat     <= 1'b0;
      res_upd      <= 1'b0;
      out_valid    <= 1'b0;
      rate_bpm     <= '0;
      beat_seen    <= 1'b0;
      rate_updated <= 1'b0;
    end else begin
      // result taken and nothing new to load this cycle
      if (out_valid && !out_stall && (state != ST_PUSH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_beat <= beat_now;
            res_upd  <= qualify;
            if (blank_left != '0) begin
              blank_left <= blank_left - BLANK_W'(1);
              elapsed    <= elapsed_inc;
            end else if (beat_now) begin
              have_prior <= 1'b1;
              elapsed    <= '0;
              blank_left <= cfg.blank_ticks;
            end else begin
              elapsed <= elapsed_inc;
            end
            state <= qualify ? ST_DIV : ST_PUSH;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            held_rate <= (div_q > DIV_W'(RATE_MAX)) ? RATE_MAX : div_q[RATE_W-1:0];
            state     <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            rate_bpm     <= held_rate;
            beat_seen    <= res_beat;
            rate_updated <= res_upd;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // an updated rate only comes with a beat
  a_upd_needs_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (beat_seen || !rate_updated))
    else $error("rate update without a beat");

  // a stalled result holds steady until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable({rate_bpm, beat_seen, rate_updated})))
    else $error("stalled result changed");

  // a beat opens the blanking window with the configured length
  a_blank_load: assert property (@(posedge clk) disable iff (rst)
    (accept && beat_now) |=> (blank_left == $past(cfg.blank_ticks)))
    else $error("blanking window not loaded on beat");

  // divider result is only expected while waiting for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

endmodule
